FILE: rtl/three_fraction_lcm_add_sub_defines.svh
// assertion macros for the three-fraction lcm add/sub block
// no dependencies; included by the top level
`ifndef THREE_FRACTION_LCM_ADD_SUB_DEFINES_SVH
`define THREE_FRACTION_LCM_ADD_SUB_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TFL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tfl same-cycle check failed");

// next-cycle implication, disabled during reset
`define TFL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tfl next-cycle check failed");

`endif

FILE: rtl/tfl_pkg.sv
// shared types and constants for the three-fraction lcm add/sub block
// used by tfl_div and three_fraction_lcm_add_sub
package tfl_pkg;

    localparam int NUM_WIDTH_DEF         = 16;
    localparam int DEN_WIDTH_DEF         = 8;
    localparam int MAX_CANCEL_FACTOR_DEF = 7;

    localparam int ONUM_W = 42;
    localparam int ODEN_W = 24;
    localparam int STAT_W = 2;
    localparam int CMD_W  = 3;

    localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_BAD_DEN = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_BAD_OP  = 2'd2;

    localparam logic [CMD_W-1:0] CMD_ADD_ADD = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SUB_SUB = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ADD_SUB = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SUB_ADD = 3'd4;

    typedef struct packed {
        logic busy;
        logic done;
    } tfl_div_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GCD,
        ST_GCD_STEP,
        ST_DIV_WAIT,
        ST_LCM_MUL,
        ST_LCM_CHK,
        ST_TERM,
        ST_TERM_MUL,
        ST_TERM_ACC,
        ST_CAN,
        ST_CAN_NUM,
        ST_CAN_DEN,
        ST_SAT,
        ST_FINISH
    } tfl_state_t;

endpackage

FILE: rtl/tfl_div.sv
// restoring unsigned divider, one quotient bit per cycle
// depends on tfl_pkg for the status struct
module tfl_div
    import tfl_pkg::*;
#(
    parameter int DVD_W = 42,
    parameter int DVS_W = 24
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DVD_W-1:0] quot,
    output logic [DVS_W-1:0] rem,
    output tfl_div_stat_t    stat
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVS_W:0]   rem_reg;
    logic [DVD_W-1:0] quot_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0] shifted;
    logic [DVS_W:0] diff;
    logic           fits;

    assign shifted = {rem_reg[DVS_W-1:0], quot_reg[DVD_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quot_reg <= dividend;
            dvs_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? diff : shifted;
            quot_reg <= {quot_reg[DVD_W-2:0], fits};
        end
    end

    assign quot      = quot_reg;
    assign rem       = rem_reg[DVS_W-1:0];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

FILE: rtl/three_fraction_lcm_add_sub.sv
// three-fraction add/sub over the lcm of the denominators, with factor cancellation
// each pass through the shared divider holds the sequencer in ST_DIV_WAIT until done;
// the time an ok item takes is set by euclid steps and factors removed,
// a zero denominator goes from idle to ST_FINISH, then to the output slot once it has room
// throughput: one item in flight, s_tready is high only while the sequencer is idle
// reset: rst_n async active low clears sequencer and output valid; needs tfl_pkg, tfl_div
`include "three_fraction_lcm_add_sub_defines.svh"

module three_fraction_lcm_add_sub
    import tfl_pkg::*;
#(
    parameter int NUM_WIDTH         = NUM_WIDTH_DEF,
    parameter int DEN_WIDTH         = DEN_WIDTH_DEF,
    parameter int MAX_CANCEL_FACTOR = MAX_CANCEL_FACTOR_DEF,
    localparam int IN_W             = 3 * (NUM_WIDTH + DEN_WIDTH),
    localparam int S_TDATA_W        = ((IN_W + 7) / 8) * 8,
    localparam int M_TDATA_W        = ((ONUM_W + ODEN_W + 7) / 8) * 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // num_one, den_one, num_two, den_two, num_three, den_three, zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    // cmd
    input  logic [CMD_W-1:0]     s_tuser,
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // out_numerator, out_denominator, zero fill
    output logic [M_TDATA_W-1:0] m_tdata,
    // status
    output logic [STAT_W-1:0]    m_tuser
);

    // accumulator holds three scaled terms exactly
    localparam int ACC_W  = NUM_WIDTH + ODEN_W + 2;
    localparam int MOP_W  = ODEN_W + 1;
    localparam int MUL_W  = 2 * MOP_W;
    localparam int K_W    = $clog2(MAX_CANCEL_FACTOR + 2);
    localparam int SAT_W  = (ACC_W > ONUM_W) ? ACC_W : ONUM_W;
    localparam int FILL_W = M_TDATA_W - ONUM_W - ODEN_W;

    // input beat fields
    logic signed [NUM_WIDTH-1:0] in_num [3];
    logic        [DEN_WIDTH-1:0] in_den [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            in_num[i] = s_tdata[i*(NUM_WIDTH+DEN_WIDTH) +: NUM_WIDTH];
            in_den[i] = s_tdata[i*(NUM_WIDTH+DEN_WIDTH) + NUM_WIDTH +: DEN_WIDTH];
        end
    end

    // sequencer state and working registers
    tfl_state_t state_reg, state_next;
    tfl_state_t ret_reg, ret_next;

    logic signed [NUM_WIDTH-1:0] num_reg [3];
    logic signed [NUM_WIDTH-1:0] num_next [3];
    logic        [DEN_WIDTH-1:0] den_reg [3];
    logic        [DEN_WIDTH-1:0] den_next [3];
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [ODEN_W-1:0] x_reg, x_next;
    logic [ODEN_W-1:0] y_reg, y_next;
    logic [ODEN_W-1:0] common_reg, common_next;
    logic              phase_reg, phase_next;
    logic [1:0]        idx_reg, idx_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [ACC_W-1:0]  aq_reg, aq_next;
    logic signed [MUL_W-1:0] prod_reg, prod_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic signed [ONUM_W-1:0] res_num_reg, res_num_next;

    // output slot
    logic                     m_valid_reg, m_valid_next;
    logic signed [ONUM_W-1:0] m_num_reg, m_num_next;
    logic [ODEN_W-1:0]        m_den_reg, m_den_next;
    logic [STAT_W-1:0]        m_stat_reg, m_stat_next;

    // shared divider
    logic              div_start;
    logic [ACC_W-1:0]  div_dvd;
    logic [ODEN_W-1:0] div_dvs;
    logic [ACC_W-1:0]  div_quot;
    logic [ODEN_W-1:0] div_rem;
    tfl_div_stat_t     div_stat;

    tfl_div #(
        .DVD_W (ACC_W),
        .DVS_W (ODEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .quot     (div_quot),
        .rem      (div_rem),
        .stat     (div_stat)
    );

    // shared multiplier, operands picked by the sequencer
    logic signed [MOP_W-1:0] mul_a;
    logic signed [MOP_W-1:0] mul_b;
    logic signed [MUL_W-1:0] mul_p;

    assign mul_p = mul_a * mul_b;

    logic              s_fire;
    logic              any_zero;
    logic              cmd_ok;
    logic [ACC_W-1:0]  acc_mag;
    logic signed [ACC_W-1:0] term;
    logic              term_neg;
    logic signed [SAT_W-1:0] acc_ext;
    logic signed [SAT_W-1:0] sat_hi;
    logic signed [SAT_W-1:0] sat_lo;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign any_zero = (in_den[0] == '0) || (in_den[1] == '0) || (in_den[2] == '0);
    assign cmd_ok   = (cmd_reg == CMD_ADD_ADD) || (cmd_reg == CMD_SUB_SUB) ||
                      (cmd_reg == CMD_ADD_SUB) || (cmd_reg == CMD_SUB_ADD);
    assign acc_mag  = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign term     = ACC_W'(prod_reg);
    assign acc_ext  = SAT_W'(acc_reg);
    assign sat_hi   = $signed(SAT_W'({1'b0, {(ONUM_W-1){1'b1}}}));
    assign sat_lo   = -sat_hi - SAT_W'(1);

    // second term is subtracted for cmd 2 and 4, third for cmd 2 and 3
    always_comb
    begin
        term_neg = 1'b0;
        if (idx_reg == 2'd1)
        begin
            term_neg = (cmd_reg == CMD_SUB_SUB) || (cmd_reg == CMD_SUB_ADD);
        end
        else if (idx_reg == 2'd2)
        begin
            term_neg = (cmd_reg == CMD_SUB_SUB) || (cmd_reg == CMD_ADD_SUB);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        cmd_next     = cmd_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        common_next  = common_reg;
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        k_next       = k_reg;
        acc_next     = acc_reg;
        aq_next      = aq_reg;
        prod_next    = prod_reg;
        status_next  = status_reg;
        res_num_next = res_num_reg;
        m_valid_next = m_valid_reg;
        m_num_next   = m_num_reg;
        m_den_next   = m_den_reg;
        m_stat_next  = m_stat_reg;
        div_start    = 1'b0;
        div_dvd      = '0;
        div_dvs      = '0;
        mul_a        = '0;
        mul_b        = '0;

        // output slot drains independently of the sequencer
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    num_next    = in_num;
                    den_next    = in_den;
                    cmd_next    = s_tuser;
                    x_next      = ODEN_W'(in_den[0]);
                    y_next      = ODEN_W'(in_den[1]);
                    phase_next  = 1'b0;
                    status_next = STATUS_OK;
                    if (any_zero)
                    begin
                        status_next = STATUS_BAD_DEN;
                        state_next  = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_GCD;
                    end
                end
            end
            ST_GCD:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
                if (y_reg == '0)
                begin
                    // gcd found in x: divide the left operand by it
                    div_dvd  = phase_reg ? ACC_W'(common_reg) : ACC_W'(den_reg[0]);
                    div_dvs  = x_reg;
                    ret_next = ST_LCM_MUL;
                end
                else
                begin
                    div_dvd  = ACC_W'(x_reg);
                    div_dvs  = y_reg;
                    ret_next = ST_GCD_STEP;
                end
            end
            ST_GCD_STEP:
            begin
                x_next     = y_reg;
                y_next     = div_rem;
                state_next = ST_GCD;
            end
            ST_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = ret_reg;
                end
            end
            ST_LCM_MUL:
            begin
                mul_a      = $signed(MOP_W'(div_quot[ODEN_W-1:0]));
                mul_b      = phase_reg ? $signed(MOP_W'(den_reg[2]))
                                       : $signed(MOP_W'(den_reg[1]));
                prod_next  = mul_p;
                state_next = ST_LCM_CHK;
            end
            ST_LCM_CHK:
            begin
                if (prod_reg[MUL_W-1:ODEN_W] != '0)
                begin
                    status_next = STATUS_BAD_DEN;
                    state_next  = ST_FINISH;
                end
                else if (!phase_reg)
                begin
                    common_next = prod_reg[ODEN_W-1:0];
                    x_next      = prod_reg[ODEN_W-1:0];
                    y_next      = ODEN_W'(den_reg[2]);
                    phase_next  = 1'b1;
                    state_next  = ST_GCD;
                end
                else if (!cmd_ok)
                begin
                    status_next = STATUS_BAD_OP;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    common_next = prod_reg[ODEN_W-1:0];
                    idx_next    = 2'd0;
                    acc_next    = '0;
                    state_next  = ST_TERM;
                end
            end
            ST_TERM:
            begin
                div_start  = 1'b1;
                div_dvd    = ACC_W'(common_reg);
                div_dvs    = ODEN_W'(den_reg[idx_reg]);
                ret_next   = ST_TERM_MUL;
                state_next = ST_DIV_WAIT;
            end
            ST_TERM_MUL:
            begin
                mul_a      = $signed(MOP_W'(div_quot[ODEN_W-1:0]));
                mul_b      = MOP_W'(num_reg[idx_reg]);
                prod_next  = mul_p;
                state_next = ST_TERM_ACC;
            end
            ST_TERM_ACC:
            begin
                acc_next = term_neg ? (acc_reg - term) : (acc_reg + term);
                if (idx_reg == 2'd2)
                begin
                    k_next     = K_W'(2);
                    state_next = ST_CAN;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_TERM;
                end
            end
            ST_CAN:
            begin
                if (k_reg > K_W'(MAX_CANCEL_FACTOR))
                begin
                    state_next = ST_SAT;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_dvd    = acc_mag;
                    div_dvs    = ODEN_W'(k_reg);
                    ret_next   = ST_CAN_NUM;
                    state_next = ST_DIV_WAIT;
                end
            end
            ST_CAN_NUM:
            begin
                if (div_rem != '0)
                begin
                    k_next     = k_reg + K_W'(1);
                    state_next = ST_CAN;
                end
                else
                begin
                    aq_next    = div_quot;
                    div_start  = 1'b1;
                    div_dvd    = ACC_W'(common_reg);
                    div_dvs    = ODEN_W'(k_reg);
                    ret_next   = ST_CAN_DEN;
                    state_next = ST_DIV_WAIT;
                end
            end
            ST_CAN_DEN:
            begin
                if (div_rem != '0)
                begin
                    k_next = k_reg + K_W'(1);
                end
                else
                begin
                    // exact division keeps the sign of the numerator
                    acc_next    = acc_reg[ACC_W-1] ? -$signed(aq_reg) : $signed(aq_reg);
                    common_next = div_quot[ODEN_W-1:0];
                end
                state_next = ST_CAN;
            end
            ST_SAT:
            begin
                priority if (acc_ext > sat_hi)
                begin
                    res_num_next = sat_hi[ONUM_W-1:0];
                end
                else if (acc_ext < sat_lo)
                begin
                    res_num_next = sat_lo[ONUM_W-1:0];
                end
                else
                begin
                    res_num_next = acc_ext[ONUM_W-1:0];
                end
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_stat_next  = status_reg;
                    if (status_reg == STATUS_OK)
                    begin
                        m_num_next = res_num_reg;
                        m_den_next = common_reg;
                    end
                    else
                    begin
                        m_num_next = '0;
                        m_den_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        num_reg     <= num_next;
        den_reg     <= den_next;
        cmd_reg     <= cmd_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        common_reg  <= common_next;
        phase_reg   <= phase_next;
        idx_reg     <= idx_next;
        k_reg       <= k_next;
        acc_reg     <= acc_next;
        aq_reg      <= aq_next;
        prod_reg    <= prod_next;
        status_reg  <= status_next;
        res_num_reg <= res_num_next;
        m_num_reg   <= m_num_next;
        m_den_reg   <= m_den_next;
        m_stat_reg  <= m_stat_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{FILL_W{1'b0}}, m_den_reg, m_num_reg};
    assign m_tuser  = m_stat_reg;

    // error results carry a zero denominator, good ones never do
    `TFL_ASSERT_IMP(a_err_den_zero, clk, rst_n,
        m_valid_reg && (m_stat_reg != STATUS_OK), m_den_reg == '0)
    `TFL_ASSERT_IMP(a_ok_den_nonzero, clk, rst_n,
        m_valid_reg && (m_stat_reg == STATUS_OK), m_den_reg != '0)
    // the divider is never restarted while it is still working
    `TFL_ASSERT_IMP(a_div_no_restart, clk, rst_n, div_start, !div_stat.busy)
    // an accepted beat always moves the sequencer out of idle
    `TFL_ASSERT_NXT(a_fire_leaves_idle, clk, rst_n, s_fire, state_reg != ST_IDLE)

endmodule

FILE: tb/sv/tb.sv
// self-checking testbench for three_fraction_lcm_add_sub
// drives random and directed fraction triples, predicts the reduced sum in-line
// depends on tfl_pkg and the three_fraction_lcm_add_sub rtl
`timescale 1ns / 1ps

module tb;
    import tfl_pkg::*;

    localparam int NW = NUM_WIDTH_DEF;
    localparam int DW = DEN_WIDTH_DEF;
    localparam int SW = ((3 * (NW + DW) + 7) / 8) * 8;
    localparam int MW = ((ONUM_W + ODEN_W + 7) / 8) * 8;
    localparam longint CYCLE_LIMIT = 20000000;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [SW-1:0]    data;
    } fraction_beat_t;

    typedef struct packed {
        logic [ONUM_W-1:0] num;
        logic [ODEN_W-1:0] den;
        logic [STAT_W-1:0] status;
    } sum_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [SW-1:0] s_tdata = '0;
    logic [CMD_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [MW-1:0] m_tdata;
    logic [STAT_W-1:0] m_tuser;

    fraction_beat_t pending_beats[$];
    sum_result_t    expected_sums[$];
    int  errors = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    bit  hold_sender = 1'b0;
    longint cycles = 0;

    three_fraction_lcm_add_sub DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 clk = ~clk;

    // no gap half the time, otherwise mostly short gaps, sometimes long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic longint unsigned euclid(longint unsigned a, longint unsigned b);
        longint unsigned t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    // expected reduced sum for one fraction triple
    function automatic sum_result_t reduce_triple(fraction_beat_t b);
        sum_result_t r;
        longint n [3];
        longint unsigned q [3];
        longint unsigned common;
        longint acc;
        longint lim;
        r = '0;
        for (int i = 0; i < 3; i++)
        begin
            n[i] = longint'($signed(b.data[i*(NW+DW) +: NW]));
            q[i] = b.data[i*(NW+DW)+NW +: DW];
        end
        if (q[0] == 0 || q[1] == 0 || q[2] == 0)
        begin
            r.status = STATUS_BAD_DEN;
            return r;
        end
        common = (q[0] / euclid(q[0], q[1])) * q[1];
        common = (common / euclid(common, q[2])) * q[2];
        if (common > (64'd1 << ODEN_W) - 1)
        begin
            r.status = STATUS_BAD_DEN;
            return r;
        end
        for (int i = 0; i < 3; i++)
            n[i] = longint'(common / q[i]) * n[i];
        case (b.cmd)
            CMD_ADD_ADD: acc = n[0] + n[1] + n[2];
            CMD_SUB_SUB: acc = n[0] - n[1] - n[2];
            CMD_ADD_SUB: acc = n[0] + n[1] - n[2];
            CMD_SUB_ADD: acc = n[0] - n[1] + n[2];
            default:
            begin
                r.status = STATUS_BAD_OP;
                return r;
            end
        endcase
        for (int k = 2; k <= MAX_CANCEL_FACTOR_DEF; k++)
            while (acc % k == 0 && common % k == 0)
            begin
                acc = acc / k;
                common = common / k;
            end
        lim = 64'sd1 <<< (ONUM_W - 1);
        if (acc > lim - 1) acc = lim - 1;
        if (acc < -lim) acc = -lim;
        r.num = acc[ONUM_W-1:0];
        r.den = common[ODEN_W-1:0];
        r.status = STATUS_OK;
        return r;
    endfunction

    function automatic fraction_beat_t make_beat(logic [CMD_W-1:0] c,
                                                 logic [NW-1:0] n0, logic [DW-1:0] d0,
                                                 logic [NW-1:0] n1, logic [DW-1:0] d1,
                                                 logic [NW-1:0] n2, logic [DW-1:0] d2);
        fraction_beat_t b;
        b = '0;
        b.cmd = c;
        b.data[3*(NW+DW)-1:0] = {d2, n2, d1, n1, d0, n0};
        return b;
    endfunction

    function automatic logic [DW-1:0] rand_den();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return '0;
        if (r < 60) return DW'($urandom_range(1, 12));
        return DW'($urandom_range(1, (1 << DW) - 1));
    endfunction

    function automatic logic [NW-1:0] rand_num();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return NW'(0);
        if (r < 4) return NW'($urandom_range(0, 40) - 20);
        return NW'($urandom);
    endfunction

    function automatic logic [CMD_W-1:0] rand_cmd();
        if ($urandom_range(0, 9) == 0) return CMD_W'($urandom_range(0, 7));
        return CMD_W'($urandom_range(CMD_ADD_ADD, CMD_SUB_ADD));
    endfunction

    // driver: pops the pending queue, holds valid until the handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                expected_sums.push_back(reduce_triple({s_tuser, s_tdata}));
                send_gap = pick_gap();
            end
            if (!s_tvalid || s_tready)
            begin
                if (hold_sender || send_gap > 0 || pending_beats.size() == 0)
                begin
                    if (send_gap > 0) send_gap--;
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    fraction_beat_t b;
                    b = pending_beats.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= b.data;
                    s_tuser <= b.cmd;
                end
            end
        end
    end

    // monitor: compares each result beat against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_sums.size() == 0)
                begin
                    $display("%0t: unexpected result num=%h den=%h status=%0d", $time,
                             m_tdata[ONUM_W-1:0], m_tdata[ONUM_W +: ODEN_W], m_tuser);
                    errors++;
                end
                else
                begin
                    sum_result_t e;
                    e = expected_sums.pop_front();
                    if (m_tdata[ONUM_W-1:0] !== e.num)
                    begin
                        $display("%0t: numerator expected %0d actual %0d", $time,
                                 $signed(e.num), $signed(m_tdata[ONUM_W-1:0]));
                        errors++;
                    end
                    if (m_tdata[ONUM_W +: ODEN_W] !== e.den)
                    begin
                        $display("%0t: denominator expected %0d actual %0d", $time,
                                 e.den, m_tdata[ONUM_W +: ODEN_W]);
                        errors++;
                    end
                    if (m_tuser !== e.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 e.status, m_tuser);
                        errors++;
                    end
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) recv_gap = pick_gap();
            end
        end
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        // directed: extremes, every operation, invalid denominators and opcodes
        pending_beats.push_back(make_beat(CMD_ADD_ADD, 16'sd1, 8'd2, 16'sd1, 8'd3, 16'sd1, 8'd6));
        pending_beats.push_back(make_beat(CMD_SUB_SUB, 16'sd5, 8'd4, 16'sd1, 8'd8, 16'sd3, 8'd2));
        pending_beats.push_back(make_beat(CMD_ADD_SUB, 16'sd7, 8'd5, 16'sd2, 8'd7, 16'sd9, 8'd3));
        pending_beats.push_back(make_beat(CMD_SUB_ADD, -16'sd3, 8'd9, 16'sd4, 8'd6, 16'sd1, 8'd4));
        pending_beats.push_back(make_beat(CMD_ADD_ADD, 16'h7fff, 8'd255, 16'h7fff, 8'd254,
                                          16'h7fff, 8'd253));
        pending_beats.push_back(make_beat(CMD_SUB_SUB, 16'h8000, 8'd255, 16'h7fff, 8'd254,
                                          16'h7fff, 8'd251));
        pending_beats.push_back(make_beat(CMD_ADD_ADD, 16'h8000, 8'd1, 16'h8000, 8'd1,
                                          16'h8000, 8'd1));
        pending_beats.push_back(make_beat(CMD_ADD_ADD, 16'hffff, 8'd128, 16'h0, 8'd64,
                                          16'h1, 8'd32));
        // zero numerator, denominator reduced alone
        pending_beats.push_back(make_beat(CMD_ADD_ADD, 16'sd0, 8'd210, 16'sd0, 8'd2,
                                          16'sd0, 8'd3));
        pending_beats.push_back(make_beat(CMD_SUB_SUB, 16'sd6, 8'd6, 16'sd3, 8'd6,
                                          16'sd3, 8'd6));
        // zero denominators in each position
        pending_beats.push_back(make_beat(CMD_ADD_ADD, 16'sd1, 8'd0, 16'sd1, 8'd1, 16'sd1, 8'd1));
        pending_beats.push_back(make_beat(CMD_ADD_ADD, 16'sd1, 8'd1, 16'sd1, 8'd0, 16'sd1, 8'd1));
        pending_beats.push_back(make_beat(CMD_ADD_ADD, 16'sd1, 8'd1, 16'sd1, 8'd1, 16'sd1, 8'd0));
        // bad denominator wins over bad opcode
        pending_beats.push_back(make_beat(3'd0, 16'sd1, 8'd0, 16'sd1, 8'd1, 16'sd1, 8'd1));
        for (int c = 0; c < 8; c++)
            if (c < CMD_ADD_ADD || c > CMD_SUB_ADD)
                pending_beats.push_back(make_beat(CMD_W'(c), 16'sd1, 8'd3, 16'sd2, 8'd5,
                                                  16'sd4, 8'd7));
        // large coprime lcm
        pending_beats.push_back(make_beat(CMD_SUB_ADD, 16'h8000, 8'd251, 16'h7fff, 8'd241,
                                          16'h8000, 8'd239));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_beats.size() == 0);
        // let the block drain completely before the random part
        hold_sender = 1'b1;
        @(posedge clk);
        wait (expected_sums.size() == 0 && !s_tvalid);
        hold_sender = 1'b0;

        for (int i = 0; i < 500; i++)
        begin
            pending_beats.push_back(make_beat(rand_cmd(), rand_num(), rand_den(),
                                              rand_num(), rand_den(), rand_num(), rand_den()));
            if (i == 250)
            begin
                wait (pending_beats.size() == 0);
                hold_sender = 1'b1;
                @(posedge clk);
                wait (expected_sums.size() == 0 && !s_tvalid);
                hold_sender = 1'b0;
            end
        end

        wait (pending_beats.size() == 0);
        @(posedge clk);
        wait (expected_sums.size() == 0 && !s_tvalid);
        repeat (500) @(posedge clk);
        if (errors == 0 && expected_sums.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

FILE: files.f
+incdir+rtl
rtl/tfl_pkg.sv
rtl/tfl_div.sv
rtl/three_fraction_lcm_add_sub.sv
tb/sv/tb.sv
